@@ hdl/bmsl_pkg.sv @@
// ----------------------------------------------------------------------------
// bmsl_pkg - shared types and constants for the status LED sequencer
// Mode encoding, register indexes, reset values and the control-state struct.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bmsl_pkg;

  localparam int unsigned TimeWidthDef = 32;
  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 16;

  // register indexes
  localparam logic [CfgIdxWidth-1:0] CFG_INIT_HOLD   = 3'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_DEBOUNCE    = 3'd1;
  localparam logic [CfgIdxWidth-1:0] CFG_SLOW_PERIOD = 3'd2;
  localparam logic [CfgIdxWidth-1:0] CFG_FAST_PERIOD = 3'd3;
  localparam logic [CfgIdxWidth-1:0] CFG_PAUSE_LEN   = 3'd4;
  localparam logic [CfgIdxWidth-1:0] CFG_BLINK_TGL   = 3'd5;

  // register reset values
  localparam logic [15:0] InitHoldRst   = 16'd500;
  localparam logic [15:0] DebounceRst   = 16'd200;
  localparam logic [15:0] SlowPeriodRst = 16'd500;
  localparam logic [15:0] FastPeriodRst = 16'd200;
  localparam logic [15:0] PauseLenRst   = 16'd500;
  localparam logic [3:0]  BlinkTglRst   = 4'd4;

  // external mode codes
  localparam logic [2:0] MODE_CODE_INIT   = 3'd0;
  localparam logic [2:0] MODE_CODE_IDLE   = 3'd1;
  localparam logic [2:0] MODE_CODE_MANUAL = 3'd2;
  localparam logic [2:0] MODE_CODE_LOCK   = 3'd3;
  localparam logic [2:0] MODE_CODE_AUTO   = 3'd4;

  typedef enum logic [4:0] {
    MODE_INIT   = 5'b00001,
    MODE_IDLE   = 5'b00010,
    MODE_MANUAL = 5'b00100,
    MODE_LOCK   = 5'b01000,
    MODE_AUTO   = 5'b10000
  } mode_e;

  typedef struct packed {
    logic [15:0] init_hold;
    logic [15:0] debounce_gap;
    logic [15:0] slow_period;
    logic [15:0] fast_period;
    logic [15:0] pause_length;
    logic [3:0]  blink_toggles;
  } cfg_t;

  // non-time sequencer state
  typedef struct packed {
    mode_e      mode;
    logic       blink_phase;  // 0 pause, 1 burst
    logic [3:0] burst_count;
    logic       led_level;
  } ctrl_t;

  function automatic logic [2:0] mode_code(mode_e m);
    logic [2:0] code;
    case (m)
      MODE_INIT:   code = MODE_CODE_INIT;
      MODE_IDLE:   code = MODE_CODE_IDLE;
      MODE_MANUAL: code = MODE_CODE_MANUAL;
      MODE_LOCK:   code = MODE_CODE_LOCK;
      MODE_AUTO:   code = MODE_CODE_AUTO;
      default:     code = MODE_CODE_INIT;
    endcase
    return code;
  endfunction

endpackage

@@ hdl/bmsl_step.sv @@
// ----------------------------------------------------------------------------
// bmsl_step - next-state logic for one tick
// Debounce, init timeout, mode advance and the per-mode LED rule.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmsl_step #(
  parameter int unsigned TIME_WIDTH = bmsl_pkg::TimeWidthDef
) (
  input  bmsl_pkg::cfg_t         cfg_i,
  input  bmsl_pkg::ctrl_t        ctrl_i,
  input  logic [TIME_WIDTH-1:0]  now_i,
  input  logic [TIME_WIDTH-1:0]  entry_i,
  input  logic [TIME_WIDTH-1:0]  press_i,
  input  logic [TIME_WIDTH-1:0]  toggle_i,
  input  logic                   button_edge_i,
  output bmsl_pkg::ctrl_t        ctrl_o,
  output logic [TIME_WIDTH-1:0]  now_o,
  output logic [TIME_WIDTH-1:0]  entry_o,
  output logic [TIME_WIDTH-1:0]  press_o,
  output logic [TIME_WIDTH-1:0]  toggle_o
);
  import bmsl_pkg::*;

  logic [TIME_WIDTH-1:0] now_n;
  logic [TIME_WIDTH-1:0] since_press;
  logic [TIME_WIDTH-1:0] since_entry;
  logic [TIME_WIDTH-1:0] since_toggle;
  logic [TIME_WIDTH-1:0] period;
  logic                  pressed;
  ctrl_t                 c;
  logic [TIME_WIDTH-1:0] entry_n;
  logic [TIME_WIDTH-1:0] toggle_n;

  assign now_n       = now_i + TIME_WIDTH'(1);
  assign since_press = now_n - press_i;
  assign since_entry = now_n - entry_i;
  assign pressed     = button_edge_i && (since_press >= TIME_WIDTH'(cfg_i.debounce_gap));

  always_comb begin
    c        = ctrl_i;
    entry_n  = entry_i;
    toggle_n = toggle_i;

    // init timeout
    if (c.mode == MODE_INIT && since_entry >= TIME_WIDTH'(cfg_i.init_hold)) begin
      c.led_level = 1'b0;
      c.mode      = MODE_IDLE;
      entry_n     = now_n;
    end

    // mode advance
    if (pressed) begin
      case (c.mode)
        MODE_IDLE:   c.mode = MODE_MANUAL;
        MODE_MANUAL: c.mode = MODE_LOCK;
        MODE_LOCK: begin
          c.mode        = MODE_AUTO;
          c.blink_phase = 1'b0;
          c.burst_count = 4'd0;
          toggle_n      = now_n;
        end
        default:     c.mode = MODE_IDLE;
      endcase
      entry_n = now_n;
    end

    // LED rule of the resulting mode
    since_toggle = now_n - toggle_n;
    period       = (c.mode == MODE_IDLE) ? TIME_WIDTH'(cfg_i.slow_period)
                                         : TIME_WIDTH'(cfg_i.fast_period);
    case (c.mode)
      MODE_IDLE, MODE_AUTO: begin
        if (since_toggle >= period) begin
          toggle_n    = now_n;
          c.led_level = ~c.led_level;
        end
      end
      MODE_MANUAL: c.led_level = 1'b1;
      MODE_LOCK: begin
        if (!c.blink_phase) begin
          c.led_level = 1'b0;
          if (since_toggle >= TIME_WIDTH'(cfg_i.pause_length)) begin
            toggle_n      = now_n;
            c.burst_count = 4'd0;
            c.blink_phase = 1'b1;
          end
        end else if (since_toggle >= period) begin
          toggle_n      = now_n;
          c.led_level   = ~c.led_level;
          c.burst_count = c.burst_count + 4'd1;
          if (c.burst_count >= cfg_i.blink_toggles) begin
            c.burst_count = 4'd0;
            c.blink_phase = 1'b0;
          end
        end
      end
      default: c.burst_count = 4'd0;
    endcase
  end

  assign ctrl_o   = c;
  assign now_o    = now_n;
  assign entry_o  = entry_n;
  assign press_o  = pressed ? now_n : press_i;
  assign toggle_o = toggle_n;

endmodule

@@ hdl/button_mode_status_led_sequencer_core.sv @@
// ----------------------------------------------------------------------------
// button_mode_status_led_sequencer_core - mode button and status LED sequencer
// Result timing: a result beat is valid in the cycle after its tick beat is accepted.
// Throughput: one tick per cycle while no result is held back; the next-state
// logic is combinational between the state registers, output register stalls only on m_axis_tready.
// Reset: asynchronous, active low; mode init with LED lit, all times zero,
// registers at their defaults, no result pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module button_mode_status_led_sequencer_core #(
  parameter int unsigned TIME_WIDTH = bmsl_pkg::TimeWidthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [bmsl_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [bmsl_pkg::CfgDataWidth-1:0] cfg_wdata_i,
  // tick stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // [0] button_edge
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [7:0]                        m_axis_tdata   // [0] led_on, [3:1] mode
);
  import bmsl_pkg::*;

  // configuration registers
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.init_hold     <= InitHoldRst;
      cfg_q.debounce_gap  <= DebounceRst;
      cfg_q.slow_period   <= SlowPeriodRst;
      cfg_q.fast_period   <= FastPeriodRst;
      cfg_q.pause_length  <= PauseLenRst;
      cfg_q.blink_toggles <= BlinkTglRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_INIT_HOLD:   cfg_q.init_hold     <= cfg_wdata_i;
        CFG_DEBOUNCE:    cfg_q.debounce_gap  <= cfg_wdata_i;
        CFG_SLOW_PERIOD: cfg_q.slow_period   <= cfg_wdata_i;
        CFG_FAST_PERIOD: cfg_q.fast_period   <= cfg_wdata_i;
        CFG_PAUSE_LEN:   cfg_q.pause_length  <= cfg_wdata_i;
        CFG_BLINK_TGL:   cfg_q.blink_toggles <= cfg_wdata_i[3:0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  // handshake: take a tick whenever the output register is free or draining
  logic s_fire;
  logic out_valid_q;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  // sequencer state
  ctrl_t                 ctrl_q, ctrl_d;
  logic [TIME_WIDTH-1:0] now_q, now_d;
  logic [TIME_WIDTH-1:0] entry_q, entry_d;
  logic [TIME_WIDTH-1:0] press_q, press_d;
  logic [TIME_WIDTH-1:0] toggle_q, toggle_d;

  bmsl_step #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_step (
    .cfg_i         (cfg_q),
    .ctrl_i        (ctrl_q),
    .now_i         (now_q),
    .entry_i       (entry_q),
    .press_i       (press_q),
    .toggle_i      (toggle_q),
    .button_edge_i (s_axis_tdata[0]),
    .ctrl_o        (ctrl_d),
    .now_o         (now_d),
    .entry_o       (entry_d),
    .press_o       (press_d),
    .toggle_o      (toggle_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q.mode        <= MODE_INIT;
      ctrl_q.blink_phase <= 1'b0;
      ctrl_q.burst_count <= 4'd0;
      ctrl_q.led_level   <= 1'b1;
      now_q              <= '0;
      entry_q            <= '0;
      press_q            <= '0;
      toggle_q           <= '0;
    end else if (s_fire) begin
      ctrl_q   <= ctrl_d;
      now_q    <= now_d;
      entry_q  <= entry_d;
      press_q  <= press_d;
      toggle_q <= toggle_d;
    end
  end

  // result register
  logic       led_out_q;
  logic [2:0] mode_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      led_out_q  <= ctrl_d.led_level;
      mode_out_q <= mode_code(ctrl_d.mode);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, mode_out_q, led_out_q};

`ifndef SYNTHESIS
  // tick counter moves by exactly one per accepted beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> now_q == $past(now_q) + TIME_WIDTH'(1))
    else $error("tick count did not advance by one");

  // init is only left, never re-entered, and holds the LED lit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_q.mode == MODE_INIT |-> ctrl_q.led_level)
    else $error("LED dark while in init");

  // burst phase exists only inside lock
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_q.blink_phase |-> ctrl_q.mode == MODE_LOCK)
    else $error("blink burst outside lock");

  // a manual-mode result always shows the LED lit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[3:1] == MODE_CODE_MANUAL |-> m_axis_tdata[0])
    else $error("manual result with LED dark");
`endif

endmodule
